/* src/fea_pkg.sv */
package fea_pkg;

    localparam int MAX_EXTENTS = 16;
    localparam int ADDR_BITS   = 16;
    localparam int IDX_BITS    = $clog2(MAX_EXTENTS);
    localparam int CNT_BITS    = $clog2(MAX_EXTENTS + 1);

    typedef logic [ADDR_BITS-1:0] addr_t;
    typedef logic [ADDR_BITS:0]   addr_wide_t;
    typedef logic [IDX_BITS-1:0]  idx_t;
    typedef logic [CNT_BITS-1:0]  cnt_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BOUNDS = 2'd1,
        ST_NOFIT  = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef struct packed {
        logic load;
        logic apply;
    } dp_cmd_t;

    typedef struct packed {
        status_t status;
        cnt_t    count;
    } dp_status_t;

endpackage

/* src/fea_datapath.sv */
module fea_datapath
    import fea_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  addr_t      cfg_size,
    input  dp_cmd_t    cmd,
    input  logic       op_in,
    input  addr_t      start_in,
    input  addr_t      length_in,
    output dp_status_t stat
);

    addr_t      starts_reg  [MAX_EXTENTS];
    addr_t      lengths_reg [MAX_EXTENTS];
    addr_t      starts_next  [MAX_EXTENTS];
    addr_t      lengths_next [MAX_EXTENTS];
    cnt_t       used_reg, used_next;
    addr_wide_t size_reg;
    logic       op_reg;
    addr_t      s_reg, l_reg;

    logic [MAX_EXTENTS-1:0] contain_reg, below_reg;
    logic [MAX_EXTENTS-1:0] contain_c, below_c;
    logic       bounds_reg, bounds_c;
    status_t    status_c;

    always_comb
    begin
        addr_wide_t e;
        addr_wide_t xe;
        e = {1'b0, start_in} + {1'b0, length_in};
        bounds_c = (length_in == '0) || (e > size_reg);
        for (int i = 0; i < MAX_EXTENTS; i++)
        begin
            xe = {1'b0, starts_reg[i]} + {1'b0, lengths_reg[i]};
            contain_c[i] = (CNT_BITS'(i) < used_reg) && (starts_reg[i] <= start_in)
                           && (e <= xe);
            below_c[i]   = (CNT_BITS'(i) < used_reg) && (starts_reg[i] < start_in);
        end
    end

    always_comb
    begin
        addr_wide_t e;
        addr_wide_t xe;
        addr_wide_t pe;
        logic       found;
        idx_t       ci;
        cnt_t       p;
        logic       left, right;
        e = {1'b0, s_reg} + {1'b0, l_reg};
        xe = '0;
        pe = '0;
        left = 1'b0;
        right = 1'b0;
        found = 1'b0;
        ci = '0;
        p  = '0;
        for (int i = 0; i < MAX_EXTENTS; i++)
        begin
            starts_next[i]  = starts_reg[i];
            lengths_next[i] = lengths_reg[i];
            if (contain_reg[i] && !found)
            begin
                found = 1'b1;
                ci = IDX_BITS'(i);
            end
            if (below_reg[i])
                p = CNT_BITS'(i + 1);
        end
        used_next = used_reg;
        status_c  = ST_OK;
        if (bounds_reg)
            status_c = ST_BOUNDS;
        else if (op_reg == OP_ALLOC)
        begin
            xe = {1'b0, starts_reg[ci]} + {1'b0, lengths_reg[ci]};
            if (!found)
                status_c = ST_NOFIT;
            else if (starts_reg[ci] == s_reg && e == xe)
            begin
                for (int i = 0; i < MAX_EXTENTS - 1; i++)
                    if (IDX_BITS'(i) >= ci)
                    begin
                        starts_next[i]  = starts_reg[i+1];
                        lengths_next[i] = lengths_reg[i+1];
                    end
                used_next = used_reg - 1'b1;
            end
            else if (starts_reg[ci] == s_reg)
            begin
                starts_next[ci]  = e[ADDR_BITS-1:0];
                lengths_next[ci] = ADDR_BITS'(xe - e);
            end
            else if (e == xe)
                lengths_next[ci] = s_reg - starts_reg[ci];
            else if (used_reg >= CNT_BITS'(MAX_EXTENTS))
                status_c = ST_FULL;
            else
            begin
                for (int i = 1; i < MAX_EXTENTS; i++)
                    if (IDX_BITS'(i) > ci + 1'b1 && CNT_BITS'(i) <= used_reg)
                    begin
                        starts_next[i]  = starts_reg[i-1];
                        lengths_next[i] = lengths_reg[i-1];
                    end
                lengths_next[ci] = s_reg - starts_reg[ci];
                starts_next[ci+1'b1]  = e[ADDR_BITS-1:0];
                lengths_next[ci+1'b1] = ADDR_BITS'(xe - e);
                used_next = used_reg + 1'b1;
            end
        end
        else
        begin
            if (p != '0)
                pe = {1'b0, starts_reg[IDX_BITS'(p - 1'b1)]}
                   + {1'b0, lengths_reg[IDX_BITS'(p - 1'b1)]};
            left  = (p != '0) && (pe == {1'b0, s_reg});
            right = (p < used_reg) && ({1'b0, starts_reg[IDX_BITS'(p)]} == e);
            if ((p != '0) && (pe > {1'b0, s_reg}))
                status_c = ST_NOFIT;
            else if ((p < used_reg) && ({1'b0, starts_reg[IDX_BITS'(p)]} < e))
                status_c = ST_NOFIT;
            else if (left && right)
            begin
                lengths_next[IDX_BITS'(p - 1'b1)] = lengths_reg[IDX_BITS'(p - 1'b1)]
                    + l_reg + lengths_reg[IDX_BITS'(p)];
                for (int i = 0; i < MAX_EXTENTS - 1; i++)
                    if (CNT_BITS'(i) >= p)
                    begin
                        starts_next[i]  = starts_reg[i+1];
                        lengths_next[i] = lengths_reg[i+1];
                    end
                used_next = used_reg - 1'b1;
            end
            else if (left)
                lengths_next[IDX_BITS'(p - 1'b1)] = lengths_reg[IDX_BITS'(p - 1'b1)] + l_reg;
            else if (right)
            begin
                starts_next[IDX_BITS'(p)]  = s_reg;
                lengths_next[IDX_BITS'(p)] = lengths_reg[IDX_BITS'(p)] + l_reg;
            end
            else if (used_reg >= CNT_BITS'(MAX_EXTENTS))
                status_c = ST_FULL;
            else
            begin
                for (int i = 1; i < MAX_EXTENTS; i++)
                    if (CNT_BITS'(i) > p && CNT_BITS'(i) <= used_reg)
                    begin
                        starts_next[i]  = starts_reg[i-1];
                        lengths_next[i] = lengths_reg[i-1];
                    end
                starts_next[IDX_BITS'(p)]  = s_reg;
                lengths_next[IDX_BITS'(p)] = l_reg;
                used_next = used_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= CNT_BITS'(1);
            size_reg <= {1'b0, {ADDR_BITS{1'b1}}};
            for (int i = 0; i < MAX_EXTENTS; i++)
            begin
                starts_reg[i]  <= '0;
                lengths_reg[i] <= '0;
            end
            lengths_reg[0] <= {ADDR_BITS{1'b1}};
        end
        else if (cfg_we)
        begin
            size_reg       <= {1'b0, cfg_size};
            used_reg       <= (cfg_size == '0) ? CNT_BITS'(0) : CNT_BITS'(1);
            starts_reg[0]  <= '0;
            lengths_reg[0] <= cfg_size;
        end
        else if (cmd.apply)
        begin
            used_reg <= used_next;
            for (int i = 0; i < MAX_EXTENTS; i++)
            begin
                starts_reg[i]  <= starts_next[i];
                lengths_reg[i] <= lengths_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg      <= op_in;
            s_reg       <= start_in;
            l_reg       <= length_in;
            contain_reg <= contain_c;
            below_reg   <= below_c;
            bounds_reg  <= bounds_c;
        end
    end

    assign stat.status = status_c;
    assign stat.count  = used_next;

endmodule

/* src/fea_control.sv */
module fea_control
    import fea_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t stat,
    output dp_cmd_t    cmd,
    output logic [1:0] status,
    output logic [4:0] extent_count
);

    typedef enum logic {
        S_IDLE,
        S_APPLY
    } state_t;

    state_t     state_reg;
    logic       out_valid_reg;
    logic [1:0] status_reg;
    logic [4:0] count_reg;

    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign cmd.load  = in_valid && in_ready;
    assign cmd.apply = (state_reg == S_APPLY);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            status_reg    <= '0;
            count_reg     <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd.load)
                        state_reg <= S_APPLY;
                end
                S_APPLY:
                begin
                    status_reg    <= stat.status;
                    count_reg     <= 5'(stat.count);
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign extent_count = count_reg;

endmodule

/* src/free_extent_allocator.sv */
// Channel   Handshake            Payload
// in        in_valid/in_ready    operation, range_start, range_length
// out       out_valid/out_ready  status, extent_count
// cfg       cfg_we               cfg_data (total_size)
// Each item is compared against all extents in parallel and the match bits
// registered, then the table is shifted and the result registered; the next
// item enters only once the result is taken, so items never overlap.
// Reset restores one free extent [0, 65535); no clearing pass.
module free_extent_allocator
    import fea_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        operation,
    input  logic [15:0] range_start,
    input  logic [15:0] range_length,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [4:0]  extent_count
);

    dp_cmd_t    cmd;
    dp_status_t stat;

    fea_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_size  (cfg_data),
        .cmd       (cmd),
        .op_in     (operation),
        .start_in  (range_start),
        .length_in (range_length),
        .stat      (stat)
    );

    fea_control u_ctl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .stat         (stat),
        .cmd          (cmd),
        .status       (status),
        .extent_count (extent_count)
    );

endmodule

/* src/fea_checker.sv */
module fea_checker
    import fea_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] status,
    input logic [4:0] extent_count
);

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> extent_count <= 5'(MAX_EXTENTS))
        else $error("extent count above table size");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> ##1 out_valid)
        else $error("no result two cycles after item");

    a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("item accepted while result pending");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(status))
        else $error("stalled result changed");

endmodule

bind free_extent_allocator fea_checker u_chk (.*);

/* test/tb.sv */
module tb;
    import fea_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT = 400000;

    typedef struct {
        op_t         op;
        logic [15:0] start;
        logic [15:0] len;
        bit          has_want;
        status_t     want_status;
        logic [4:0]  want_count;
    } row_t;

    typedef struct {
        status_t    st;
        logic [4:0] cnt;
    } reply_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        operation = 1'b0;
    logic [15:0] range_start = '0;
    logic [15:0] range_length = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  status;
    logic [4:0]  extent_count;

    free_extent_allocator u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .range_start  (range_start),
        .range_length (range_length),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .extent_count (extent_count)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // model of the free-extent table
    int unsigned space_size;
    int unsigned ext_start [MAX_EXTENTS];
    int unsigned ext_len [MAX_EXTENTS];
    int unsigned ext_used;

    reply_t      pending_replies[$];
    int          errors = 0;
    int          n_items = 0;
    int          n_replies = 0;
    int          cycles = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          hold_off = 1'b0;
    int unsigned st_seen [4];

    task automatic report(input string what);
        $display("tb: mismatch %s (reply %0d)", what, n_replies);
        errors++;
    endtask

    function automatic void table_reset(input int unsigned sz);
        space_size = sz;
        for (int i = 0; i < MAX_EXTENTS; i++)
        begin
            ext_start[i] = 0;
            ext_len[i] = 0;
        end
        ext_used = (sz == 0) ? 0 : 1;
        ext_len[0] = sz;
    endfunction

    function automatic void drop_at(input int unsigned pos);
        for (int unsigned i = pos; i + 1 < ext_used; i++)
        begin
            ext_start[i] = ext_start[i+1];
            ext_len[i] = ext_len[i+1];
        end
        ext_used--;
        ext_start[ext_used] = 0;
        ext_len[ext_used] = 0;
    endfunction

    function automatic void add_at(input int unsigned pos, input int unsigned s,
                                   input int unsigned l);
        for (int unsigned i = ext_used; i > pos; i--)
        begin
            ext_start[i] = ext_start[i-1];
            ext_len[i] = ext_len[i-1];
        end
        ext_start[pos] = s;
        ext_len[pos] = l;
        ext_used++;
    endfunction

    function automatic status_t carve(input int unsigned s, input int unsigned l);
        int unsigned e;
        int unsigned xs;
        int unsigned xe;
        e = s + l;
        for (int unsigned i = 0; i < ext_used; i++)
        begin
            xs = ext_start[i];
            xe = xs + ext_len[i];
            if (xs <= s && e <= xe)
            begin
                if (xs == s && e == xe)
                    drop_at(i);
                else if (xs == s)
                begin
                    ext_start[i] = e;
                    ext_len[i] = xe - e;
                end
                else if (e == xe)
                    ext_len[i] = s - xs;
                else
                begin
                    if (ext_used >= MAX_EXTENTS)
                        return ST_FULL;
                    ext_len[i] = s - xs;
                    add_at(i + 1, e, xe - e);
                end
                return ST_OK;
            end
        end
        return ST_NOFIT;
    endfunction

    function automatic status_t give_back(input int unsigned s, input int unsigned l);
        int unsigned e;
        int unsigned p;
        bit lft;
        bit rgt;
        e = s + l;
        p = 0;
        while (p < ext_used && ext_start[p] < s)
            p++;
        if (p > 0 && ext_start[p-1] + ext_len[p-1] > s)
            return ST_NOFIT;
        if (p < ext_used && ext_start[p] < e)
            return ST_NOFIT;
        lft = p > 0 && ext_start[p-1] + ext_len[p-1] == s;
        rgt = p < ext_used && ext_start[p] == e;
        if (lft && rgt)
        begin
            ext_len[p-1] += l + ext_len[p];
            drop_at(p);
        end
        else if (lft)
            ext_len[p-1] += l;
        else if (rgt)
        begin
            ext_start[p] = s;
            ext_len[p] += l;
        end
        else
        begin
            if (ext_used >= MAX_EXTENTS)
                return ST_FULL;
            add_at(p, s, l);
        end
        return ST_OK;
    endfunction

    function automatic reply_t predict_reply(input op_t op, input logic [15:0] s,
                                             input logic [15:0] l);
        reply_t r;
        if (l == 0 || int'(s) + int'(l) > space_size)
            r.st = ST_BOUNDS;
        else if (op == OP_ALLOC)
            r.st = carve(s, l);
        else
            r.st = give_back(s, l);
        r.cnt = ext_used[4:0];
        return r;
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // check replies
    always @(posedge clk)
    begin
        reply_t w;
        if (rst_n && out_valid && out_ready)
        begin
            n_replies++;
            if (pending_replies.size() == 0)
                report("reply with nothing pending");
            else
            begin
                w = pending_replies.pop_front();
                if (status !== w.st)
                    report($sformatf("status %0d want %0d", status, w.st));
                if (extent_count !== w.cnt)
                    report($sformatf("count %0d want %0d", extent_count, w.cnt));
                st_seen[w.st]++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_off)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_item(input op_t op, input logic [15:0] s, input logic [15:0] l,
                             input bit has_want, input status_t ws, input logic [4:0] wc);
        reply_t r;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        range_start <= s;
        range_length <= l;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        r = predict_reply(op, s, l);
        if (has_want && (r.st != ws || r.cnt != wc))
            report("table row disagrees with prediction");
        pending_replies.push_back(r);
        n_items++;
    endtask

    task automatic drain();
        int n;
        n = 0;
        in_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        while (n < 8)
        begin
            @(posedge clk);
            n++;
        end
    endtask

    task automatic write_size(input logic [15:0] sz);
        drain();
        cfg_we <= 1'b1;
        cfg_data <= sz;
        @(posedge clk);
        cfg_we <= 1'b0;
        table_reset(sz);
    endtask

    // mostly allocate/free of plausible ranges near extent edges, some noise
    task automatic random_item();
        int unsigned k;
        int unsigned s;
        int unsigned l;
        op_t op;
        op = op_t'($urandom_range(1));
        k = $urandom_range(9);
        if (k < 6 && ext_used > 0)
        begin
            k = $urandom_range(ext_used - 1);
            if (op == OP_ALLOC)
            begin
                s = ext_start[k] + $urandom_range(ext_len[k] - 1);
                l = 1 + $urandom_range(ext_start[k] + ext_len[k] - s - 1);
                if ($urandom_range(1))
                    l = 1 + $urandom_range((l > 8) ? l / 8 : l - 1);
            end
            else
            begin
                s = ext_start[k] + ext_len[k];
                if (s >= space_size)
                    s = (space_size > 1) ? $urandom_range(space_size - 1) : 0;
                l = 1 + $urandom_range(3);
                if ($urandom_range(1))
                    s = s + $urandom_range(4);
            end
        end
        else if (k < 8)
        begin
            s = (space_size > 1) ? $urandom_range(space_size - 1) : 0;
            l = 1 + $urandom_range(space_size > 64 ? 64 : 1);
        end
        else
        begin
            s = $urandom_range(16'hFFFF);
            l = $urandom_range(16'hFFFF);
        end
        send_item(op, s[15:0], l[15:0], 1'b0, ST_OK, 5'd0);
    endtask

    row_t rows[$];

    initial
    begin
        table_reset(65535);
        // reset state, extremes, bounds
        rows = '{
            '{OP_ALLOC, 16'd0, 16'd0, 1, ST_BOUNDS, 5'd1},
            '{OP_FREE, 16'd0, 16'd0, 1, ST_BOUNDS, 5'd1},
            '{OP_ALLOC, 16'hFFFF, 16'hFFFF, 1, ST_BOUNDS, 5'd1},
            '{OP_ALLOC, 16'hFFFF, 16'd1, 1, ST_BOUNDS, 5'd1},
            '{OP_FREE, 16'd0, 16'd1, 1, ST_NOFIT, 5'd1},
            '{OP_ALLOC, 16'd0, 16'd16, 1, ST_OK, 5'd1},
            '{OP_ALLOC, 16'd0, 16'd1, 1, ST_NOFIT, 5'd1},
            '{OP_ALLOC, 16'hFFFE, 16'd1, 1, ST_OK, 5'd1},
            '{OP_ALLOC, 16'd100, 16'd10, 1, ST_OK, 5'd2},
            '{OP_ALLOC, 16'd90, 16'd30, 0, ST_OK, 5'd0},
            '{OP_FREE, 16'd100, 16'd10, 1, ST_OK, 5'd1},
            '{OP_FREE, 16'd4, 16'd4, 1, ST_OK, 5'd2},
            '{OP_FREE, 16'd5, 16'd1, 1, ST_NOFIT, 5'd2},
            '{OP_FREE, 16'd0, 16'd4, 1, ST_OK, 5'd2},
            '{OP_FREE, 16'd8, 16'd8, 1, ST_OK, 5'd1},
            '{OP_FREE, 16'hFFFE, 16'd1, 1, ST_OK, 5'd1},
            '{OP_ALLOC, 16'd16, 16'd65519, 1, ST_OK, 5'd1},
            '{OP_ALLOC, 16'd0, 16'd16, 1, ST_OK, 5'd0},
            '{OP_FREE, 16'd0, 16'hFFFF, 1, ST_OK, 5'd1}
        };
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (rows[i])
            send_item(rows[i].op, rows[i].start, rows[i].len, rows[i].has_want,
                      rows[i].want_status, rows[i].want_count);

        // fill the table with single-address holes, then overflow it
        write_size(16'd64);
        for (int i = 0; i < 16; i++)
            send_item(OP_ALLOC, 16'(2 * i + 1), 16'd1, 1'b0, ST_OK, 5'd0);
        send_item(OP_ALLOC, 16'd40, 16'd1, 1, ST_FULL, 5'd16);
        send_item(OP_FREE, 16'd3, 16'd1, 1, ST_OK, 5'd15);
        send_item(OP_ALLOC, 16'd40, 16'd1, 1, ST_OK, 5'd16);
        send_item(OP_ALLOC, 16'd44, 16'd1, 1, ST_FULL, 5'd16);

        write_size(16'd0);
        send_item(OP_FREE, 16'd0, 16'd1, 1, ST_BOUNDS, 5'd0);
        send_item(OP_ALLOC, 16'd0, 16'd1, 1, ST_BOUNDS, 5'd0);
        write_size(16'd1);
        send_item(OP_ALLOC, 16'd0, 16'd1, 1, ST_OK, 5'd0);
        send_item(OP_FREE, 16'd0, 16'd1, 1, ST_OK, 5'd1);

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 61; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 61; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            case (ph)
                0: write_size(16'hFFFF);
                2: write_size(16'd48);
                4: write_size(16'h8000);
                6: write_size(16'd2);
                default: write_size(16'($urandom_range(200, 1)));
            endcase
            if (ph == 3)
                fork
                    begin
                        int n;
                        n = 0;
                        hold_off = 1'b1;
                        while (n < 200)
                        begin
                            @(posedge clk);
                            n++;
                        end
                        hold_off = 1'b0;
                    end
                join_none
            repeat (100)
                random_item();
        end
        drain();
        $display("tb: %0d items sent, %0d replies checked over 12 size settings", n_items,
                 n_replies);
        $display("tb: replies by status ok/bounds/nofit/full = %0d/%0d/%0d/%0d",
                 st_seen[0], st_seen[1], st_seen[2], st_seen[3]);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
